@@ design/histogram_equalizer_top_macros.svh @@
// Assertion macros used by the histogram equalizer top module.
// The using module must provide clk and rst.
`ifndef HISTOGRAM_EQUALIZER_TOP_MACROS_SVH
`define HISTOGRAM_EQUALIZER_TOP_MACROS_SVH

// ante true on an edge -> cons true on the same edge
`define HISTEQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante true on an edge -> cons true on the next edge
`define HISTEQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/histeq_pkg.sv @@
package histeq_pkg;

  localparam int PIX_W = 8;  // sample, channel and map entry width

  // command selector; code 3 is unused and ignored
  typedef enum logic [1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_MAP   = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             map_ready_out;
  } result_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // bin memory write operation
  typedef enum logic [1:0] {
    BIN_NOP,
    BIN_INC,
    BIN_CLEAR
  } bin_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT_WR,
    ST_BUILD_RD,
    ST_BUILD_ACC,
    ST_BUILD_DIVST,
    ST_BUILD_DIV,
    ST_MAP_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MPH_IDLE,
    MPH_RED,
    MPH_GREEN,
    MPH_BLUE
  } map_phase_t;

endpackage

@@ design/histeq_div.sv @@
// Restoring divider, one quotient bit per cycle, PIX_W-bit quotient.
// Requires numer < 2^PIX_W * denom.
module histeq_div import histeq_pkg::*; #(
  parameter int COUNT_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [COUNT_BITS+PIX_W-1:0] numer,
  input  logic [COUNT_BITS-1:0]   denom,
  output logic                    done,
  output logic [PIX_W-1:0]        quo
);

  localparam int NUM_W  = COUNT_BITS + PIX_W;
  localparam int STEP_W = $clog2(PIX_W);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsr;
  logic [STEP_W-1:0] step;
  logic              running;
  logic              fits;

  assign fits = (rem >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      step    <= '0;
    end else if (running) begin
      step <= step + 1'b1;
      if (step == STEP_W'(PIX_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer;
      dsr <= NUM_W'(denom) << (PIX_W - 1);
    end else if (running) begin
      if (fits) begin
        rem <= rem - dsr;
      end
      quo <= {quo[PIX_W-2:0], fits};
      dsr <= dsr >> 1;
    end
  end

endmodule

@@ design/histeq_bins.sv @@
// Histogram bin store: read every cycle, clear at the addressed bin or
// increment the bin read in the previous cycle.
module histeq_bins import histeq_pkg::*; #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic                      clk,
  input  bin_op_t                   op,
  input  logic [$clog2(LEVELS)-1:0] addr,
  output logic [COUNT_BITS-1:0]     rd_data
);

  localparam int IDX_W = $clog2(LEVELS);

  logic [COUNT_BITS-1:0] mem [LEVELS];
  logic [IDX_W-1:0]      last_addr;

  always_ff @(posedge clk) begin
    rd_data   <= mem[addr];
    last_addr <= addr;
    case (op)
      BIN_INC:   mem[last_addr] <= rd_data + 1'b1;  // bin < total, no wrap
      BIN_CLEAR: mem[addr]      <= '0;
      default: begin
      end
    endcase
  end

endmodule

@@ design/histeq_map.sv @@
// Level map store with one read port. A lookup reads red, green and blue in
// turn and presents all three on done.
module histeq_map import histeq_pkg::*; #(
  parameter int LEVELS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [$clog2(LEVELS)-1:0] wr_addr,
  input  logic [PIX_W-1:0]          wr_data,
  input  logic                      look,
  input  rgb_t                      chan,
  output logic                      done,
  output rgb_t                      pix
);

  localparam int IDX_W = $clog2(LEVELS);

  logic [PIX_W-1:0] mem [LEVELS];
  logic [PIX_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] green_idx;
  logic [IDX_W-1:0] blue_idx;
  logic [PIX_W-1:0] red_q;
  logic [PIX_W-1:0] green_q;
  map_phase_t       phase;
  map_phase_t       phase_next;

  // channels past the last bin read the last entry
  function automatic logic [IDX_W-1:0] clamp(input logic [PIX_W-1:0] ch);
    if (32'(ch) >= LEVELS) begin
      return IDX_W'(LEVELS - 1);
    end
    return IDX_W'(ch);
  endfunction

  always_comb begin
    phase_next = phase;
    case (phase)
      MPH_IDLE:  if (look) phase_next = MPH_RED;
      MPH_RED:   phase_next = MPH_GREEN;
      MPH_GREEN: phase_next = MPH_BLUE;
      MPH_BLUE:  phase_next = MPH_IDLE;
      default:   phase_next = MPH_IDLE;
    endcase
  end

  always_comb begin
    case (phase)
      MPH_RED:   rd_addr = green_idx;
      MPH_GREEN: rd_addr = blue_idx;
      default:   rd_addr = clamp(chan.red);
    endcase
    done = (phase == MPH_BLUE);
    pix  = '{red: red_q, green: green_q, blue: rd_data};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MPH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (look && (phase == MPH_IDLE)) begin
      green_idx <= clamp(chan.green);
      blue_idx  <= clamp(chan.blue);
    end
    if (phase == MPH_RED) begin
      red_q <= rd_data;
    end
    if (phase == MPH_GREEN) begin
      green_q <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

@@ design/histogram_equalizer_top.sv @@
// Channel   Ports                 Handshake
// -------   -------------------   -------------------------------------------
// command   cmd (cmd_t)           taken at a rising edge with start & !busy
// result    result (result_t)     valid for one cycle while done is high
//
// Count sample: busy for 1 cycle after the transaction (bin read-modify-write);
//   a dropped sample leaves busy low.
// Map pixel: one map memory read per channel, then the result is registered
//   and strobed; a new transaction can be taken in the strobe cycle.
// Build map: busy while sweeping every bin; each bin costs a read, a cdf add,
//   a divider start, 8 bit-serial divider steps and the divider's done cycle.
// Reset: synchronous rst; afterwards a clearing pass over every bin zeroes
//   the bin and map memories while busy is high.
// The result side has no backpressure: done is a one-cycle strobe.
`include "histogram_equalizer_top_macros.svh"

module histogram_equalizer_top import histeq_pkg::*; #(
  parameter int LEVELS     = 256,
  parameter int COUNT_BITS = 24
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  localparam int IDX_W = $clog2(LEVELS);
  localparam int NUM_W = COUNT_BITS + PIX_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(LEVELS - 1);

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0]      idx;        // sweep / build bin index
  logic [IDX_W-1:0]      idx_next;
  logic [COUNT_BITS-1:0] total;      // samples counted since the last build
  logic [COUNT_BITS-1:0] cdf;        // running cumulative sum during build
  logic                  map_ready;

  logic                  accept;
  logic                  count_ok;
  logic                  idx_last;

  bin_op_t               bin_op;
  logic [IDX_W-1:0]      bin_addr;
  logic [COUNT_BITS-1:0] bin_data;

  logic                  map_we;
  logic [PIX_W-1:0]      map_wdata;
  logic                  look;
  logic                  map_done;
  rgb_t                  map_pix;

  logic                  div_start;
  logic [NUM_W-1:0]      numer;
  logic                  div_done;
  logic [PIX_W-1:0]      div_quo;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  // out-of-range samples and a saturated total are dropped
  assign count_ok = (32'(cmd.luma) < LEVELS) && (total != COUNT_MAX);
  assign idx_last = (idx == LAST_IDX);
  assign idx_next = idx_last ? '0 : idx + 1'b1;
  // cdf * 255 as a shift and subtract
  assign numer    = (NUM_W'(cdf) << PIX_W) - NUM_W'(cdf);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (idx_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FUNC_COUNT: if (count_ok) state_next = ST_COUNT_WR;
            FUNC_BUILD: state_next = ST_BUILD_RD;
            FUNC_MAP:   state_next = ST_MAP_WAIT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_COUNT_WR:    state_next = ST_IDLE;
      ST_BUILD_RD:    state_next = ST_BUILD_ACC;
      ST_BUILD_ACC:   state_next = ST_BUILD_DIVST;
      ST_BUILD_DIVST: state_next = ST_BUILD_DIV;
      ST_BUILD_DIV: begin
        if (div_done) state_next = idx_last ? ST_IDLE : ST_BUILD_RD;
      end
      ST_MAP_WAIT: if (map_done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs to the memories and the divider
  always_comb begin
    bin_op    = BIN_NOP;
    bin_addr  = idx;
    map_we    = 1'b0;
    map_wdata = '0;
    look      = 1'b0;
    div_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        bin_op = BIN_CLEAR;
        map_we = 1'b1;
      end
      ST_IDLE: begin
        bin_addr = IDX_W'(cmd.luma);   // read ahead for a count transaction
        look     = accept && (cmd.func == FUNC_MAP);
      end
      ST_COUNT_WR: bin_op = BIN_INC;
      ST_BUILD_RD: bin_op = BIN_CLEAR;  // read old count, leave bin cleared
      ST_BUILD_DIVST: div_start = 1'b1;
      ST_BUILD_DIV: begin
        map_we    = div_done;
        // empty histogram builds a zero map
        map_wdata = (total == '0) ? '0 : div_quo;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      total     <= '0;
      cdf       <= '0;
      map_ready <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: idx <= idx_next;
        ST_IDLE: begin
          if (accept && (cmd.func == FUNC_BUILD)) begin
            idx <= '0;
            cdf <= '0;
          end
        end
        ST_COUNT_WR:  total <= total + 1'b1;
        ST_BUILD_ACC: cdf <= cdf + bin_data;
        ST_BUILD_DIV: begin
          if (div_done) begin
            idx <= idx_next;
            if (idx_last) begin
              map_ready <= (total != '0);
              total     <= '0;
            end
          end
        end
        ST_MAP_WAIT: done <= map_done;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_MAP_WAIT) && map_done) begin
      result <= '{red_out: map_pix.red, green_out: map_pix.green,
                  blue_out: map_pix.blue, map_ready_out: map_ready};
    end
  end

  histeq_bins #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_bins (
    .clk     (clk),
    .op      (bin_op),
    .addr    (bin_addr),
    .rd_data (bin_data)
  );

  histeq_map #(
    .LEVELS (LEVELS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (map_we),
    .wr_addr (idx),
    .wr_data (map_wdata),
    .look    (look),
    .chan    ('{red: cmd.red_in, green: cmd.green_in, blue: cmd.blue_in}),
    .done    (map_done),
    .pix     (map_pix)
  );

  histeq_div #(
    .COUNT_BITS (COUNT_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (numer),
    .denom (total),
    .done  (div_done),
    .quo   (div_quo)
  );

  `HISTEQ_ASSERT_IMPL(a_done_idle, done, state == ST_IDLE, "result strobe while busy")
  `HISTEQ_ASSERT_IMPL(a_div_in_build, div_done, state == ST_BUILD_DIV, "stray divider done")
  `HISTEQ_ASSERT_IMPL(a_map_wr, map_we,
                      (state == ST_CLEAR) || (state == ST_BUILD_DIV), "map write out of phase")
  `HISTEQ_ASSERT_IMPL(a_count_sat, state == ST_COUNT_WR, total != COUNT_MAX,
                      "count past pixel limit")
  `HISTEQ_ASSERT_NEXT(a_build_start, accept && (cmd.func == FUNC_BUILD),
                      busy && (idx == '0), "build did not start at bin zero")

endmodule

@@ test/histogram_equalizer_top_tb.sv @@
// Histogram equalizer testbench.
//
// A short stimulus table comes first: mapping straight after reset, the
// unused selector, building from an empty histogram, a tiny histogram whose
// map can be worked out by hand, and a single-sample histogram (a step map).
// Rows whose result is obvious carry it typed in; the rest are scored by the
// in-house predictor.
//
// After that, random traffic runs in three stretches: light sender idling,
// heavy sender idling, then back-to-back. Most of it is whole equalization
// passes (a burst of samples offset from a random base, a build, a burst of
// pixel lookups). The rest is loose transactions with any selector.
// Between stretches the sender drains all outstanding results.
//
// Results are a one-cycle strobe on done; the testbench cannot stall them.
// Each strobe is popped from a FIFO of predicted pixels and compared field
// by field.
module histogram_equalizer_top_tb;
  import histeq_pkg::*;

  localparam int LEVELS     = 256;
  localparam int COUNT_BITS = 24;

  localparam logic [1:0] FUNC_SPARE = 2'd3;  // selector the block ignores

  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_CMDS   = 1950;

  // worst quiet time: a build walks every bin
  localparam int SETTLE = 12 * LEVELS + 16;

  localparam result_t NO_PIN = '0;

  typedef struct {
    cmd_t    c;
    bit      pinned;  // want holds the typed-in result
    result_t want;
  } row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  cmd_t    cmd;
  logic    busy;
  logic    done;
  result_t result;

  // typed-in result for the transaction on the bus, travels with cmd
  logic    pin_on;
  result_t pin_res;

  int      idle_pct;
  int      sent_cmds;
  int      mismatches;

  result_t pending_pixels[$];

  // predictor state
  bit [COUNT_BITS-1:0] bin_cnt [LEVELS];
  bit [COUNT_BITS-1:0] px_total;
  bit [7:0]            lut [LEVELS];
  bit                  lut_ready;

  row_t plan [DIRECTED_ROWS];

  histogram_equalizer_top #(
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cmd_t mk(logic [1:0] f, logic [7:0] l, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b);
    cmd_t c;
    c.func     = f;
    c.luma     = l;
    c.red_in   = r;
    c.green_in = g;
    c.blue_in  = b;
    return c;
  endfunction

  function automatic bit [7:0] lut_at(logic [7:0] ch);
    int idx;
    idx = int'(ch);
    if (idx >= LEVELS) idx = LEVELS - 1;
    return lut[idx];
  endfunction

  // Advance the predictor by one transaction. Returns 1 when a pixel result
  // is due, with the expected pixel in pix.
  function automatic bit equalize_step(cmd_t c, output result_t pix);
    longint unsigned cdf;
    longint unsigned q;
    pix = '0;
    case (c.func)
      FUNC_COUNT: begin
        // saturated total: further samples are dropped
        if (int'(c.luma) < LEVELS && px_total != '1) begin
          bin_cnt[c.luma] = bin_cnt[c.luma] + 1'b1;
          px_total        = px_total + 1'b1;
        end
        return 1'b0;
      end
      FUNC_BUILD: begin
        if (px_total == '0) begin
          foreach (lut[i]) lut[i] = '0;
          lut_ready = 1'b0;
        end else begin
          cdf = 0;
          for (int i = 0; i < LEVELS; i++) begin
            cdf += bin_cnt[i];
            q = (cdf * 255) / px_total;
            lut[i] = (q > 255) ? 8'd255 : 8'(q);
          end
          lut_ready = 1'b1;
        end
        foreach (bin_cnt[i]) bin_cnt[i] = '0;
        px_total = '0;
        return 1'b0;
      end
      FUNC_MAP: begin
        pix.red_out       = lut_at(c.red_in);
        pix.green_out     = lut_at(c.green_in);
        pix.blue_out      = lut_at(c.blue_in);
        pix.map_ready_out = lut_ready;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Scoreboard: pop on each done strobe, push on each accepted map transaction.
  always @(posedge clk) begin : scoreboard
    result_t guess;
    result_t want;
    bit      has_pix;
    if (!rst) begin
      if (done) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch("result strobe with nothing outstanding");
        end else begin
          want = pending_pixels.pop_front();
          check_field("red_out", result.red_out, want.red_out);
          check_field("green_out", result.green_out, want.green_out);
          check_field("blue_out", result.blue_out, want.blue_out);
          check_field("map_ready_out", result.map_ready_out, want.map_ready_out);
        end
      end
      if (start && !busy) begin
        has_pix = equalize_step(cmd, guess);
        if (has_pix) pending_pixels.push_back(pin_on ? pin_res : guess);
      end
    end
  end

  // Drive one transaction at the falling edge and hold it until accepted.
  // start stays high afterwards; the next call or an idle gap decides.
  task automatic send(cmd_t c, bit pin, result_t want);
    @(negedge clk);
    start   <= 1'b1;
    cmd     <= c;
    pin_on  <= pin;
    pin_res <= want;
    do @(posedge clk); while (busy);
    sent_cmds++;
  endtask

  // each cycle the sender idles with probability idle_pct percent
  task automatic issue(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    send(c, 1'b0, NO_PIN);
  endtask

  // Sender holds off until every outstanding pixel has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          base;
    int          spread;
    int          n_cnt;
    int          n_map;
    int          goal;
    int          pct [3];

    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    pin_on     = 1'b0;
    pin_res    = '0;
    idle_pct   = 12;
    sent_cmds  = 0;
    mismatches = 0;
    px_total   = '0;
    lut_ready  = 1'b0;
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    foreach (lut[i]) lut[i] = '0;
    pct = '{12, 57, 0};

    // Hand-worked map for samples {0, 128, 255, 255}: total 4, so
    // bins 0..127 -> 255*1/4 = 63, 128..254 -> 255*2/4 = 127, 255 -> 255.
    // Single sample at 7 gives a step: 0 below 7, 255 from 7 up.
    plan = '{
      '{mk(FUNC_MAP,   8'hFF, 8'd0,   8'd255, 8'd128), 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{mk(FUNC_SPARE, 8'hFF, 8'hFF,  8'hFF,  8'hFF),  1'b0, NO_PIN},
      '{mk(FUNC_BUILD, 8'h00, 8'h00,  8'h00,  8'h00),  1'b0, NO_PIN},
      '{mk(FUNC_MAP,   8'h00, 8'd255, 8'd0,   8'd255), 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{mk(FUNC_COUNT, 8'd0,   8'hFF, 8'hFF, 8'hFF), 1'b0, NO_PIN},
      '{mk(FUNC_COUNT, 8'd255, 8'h00, 8'h00, 8'h00), 1'b0, NO_PIN},
      '{mk(FUNC_COUNT, 8'd255, 8'h00, 8'h00, 8'h00), 1'b0, NO_PIN},
      '{mk(FUNC_COUNT, 8'd128, 8'h00, 8'h00, 8'h00), 1'b0, NO_PIN},
      '{mk(FUNC_SPARE, 8'd0,   8'h00, 8'h00, 8'h00), 1'b0, NO_PIN},
      '{mk(FUNC_BUILD, 8'hFF,  8'hFF, 8'hFF, 8'hFF), 1'b0, NO_PIN},
      '{mk(FUNC_MAP,   8'd0, 8'd0,   8'd128, 8'd255), 1'b1, '{8'd63, 8'd127, 8'd255, 1'b1}},
      '{mk(FUNC_MAP,   8'd0, 8'd127, 8'd254, 8'd1),   1'b1, '{8'd63, 8'd127, 8'd63, 1'b1}},
      '{mk(FUNC_BUILD, 8'h00, 8'h00,  8'h00,  8'h00),  1'b0, NO_PIN},
      '{mk(FUNC_MAP,   8'h00, 8'd255, 8'd255, 8'd255), 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
      '{mk(FUNC_COUNT, 8'd7,  8'h00,  8'h00,  8'h00),  1'b0, NO_PIN},
      '{mk(FUNC_BUILD, 8'h00, 8'h00,  8'h00,  8'h00),  1'b0, NO_PIN},
      '{mk(FUNC_MAP,   8'd0, 8'd6, 8'd7, 8'd255), 1'b1, '{8'd0, 8'd255, 8'd255, 1'b1}},
      '{mk(FUNC_MAP,   8'd0, 8'd0, 8'd0, 8'd0),   1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
      '{mk(FUNC_COUNT, 8'hAA, 8'h55, 8'hAA, 8'h55), 1'b0, NO_PIN},
      '{mk(FUNC_COUNT, 8'h55, 8'hAA, 8'h55, 8'hAA), 1'b0, NO_PIN},
      '{mk(FUNC_COUNT, 8'hAA, 8'h00, 8'h00, 8'h00), 1'b0, NO_PIN},
      '{mk(FUNC_BUILD, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0, NO_PIN},
      '{mk(FUNC_MAP,   8'h00, 8'h55, 8'hAA, 8'h80), 1'b0, NO_PIN},
      '{mk(FUNC_MAP,   8'hFF, 8'hFF, 8'h54, 8'h00), 1'b0, NO_PIN}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the post-reset clearing pass shows up as busy; send() waits it out
    foreach (plan[i]) send(plan[i].c, plan[i].pinned, plan[i].want);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pct[ph];
      goal     = DIRECTED_ROWS + (ph + 1) * RANDOM_CMDS / 3;
      while (sent_cmds < goal) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          // full equalization pass: samples at a random offset from a random base
          base   = $urandom_range(255);
          spread = $urandom_range(255);
          n_cnt  = $urandom_range(1, 80);
          n_map  = $urandom_range(1, 40);
          repeat (n_cnt)
            issue(mk(FUNC_COUNT, 8'(base + $urandom_range(spread)),
                     8'($urandom), 8'($urandom), 8'($urandom)));
          issue(mk(FUNC_BUILD, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom)));
          repeat (n_map)
            issue(mk(FUNC_MAP, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom)));
        end else begin
          // loose traffic: any selector, e.g. a map with no fresh build
          repeat ($urandom_range(1, 4))
            issue(mk(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom)));
        end
      end
      drain();
    end

    // catch stray strobes after the last build finishes
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // bound covers every transaction being a full build
  initial begin
    #500_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/histeq_pkg.sv
design/histeq_div.sv
design/histeq_bins.sv
design/histeq_map.sv
design/histogram_equalizer_top.sv
test/histogram_equalizer_top_tb.sv
